// ===== sv/lspd_pkg.sv =====
// Shared types and constants for the LSB stego payload deframer.
`default_nettype none

package lspd_pkg;

    // Largest extension length accepted.
    localparam int unsigned MAX_EXT = 4;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
    localparam logic [1:0] REG_MAGIC_FIRST  = 2'd1;
    localparam logic [1:0] REG_MAGIC_SECOND = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_BYTES_RST = 8'd54;
    localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'd42;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXT     = 3'd3,
        PH_DATALEN = 3'd4,
        PH_DATA    = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        K_MAGIC_OK  = 3'd0,
        K_MAGIC_BAD = 3'd1,
        K_EXT_LEN   = 3'd2,
        K_EXT_BAD   = 3'd3,
        K_EXT_CHAR  = 3'd4,
        K_DATA_LEN  = 3'd5,
        K_DATA_BYTE = 3'd6
    } kind_t;

    typedef struct packed {
        logic [7:0] header_bytes;
        logic [7:0] magic_first;
        logic [7:0] magic_second;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [31:0] value;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/lspd_parser.sv =====
// Frame parser: header skip, bit gathering and field decode, one item per step.
`default_nettype none

module lspd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             carrier_bit,
    input  wire logic             restart,
    input  wire lspd_pkg::cfg_t   cfg,
    output lspd_pkg::result_t     result
);

    import lspd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_count_reg, header_count_next;
    logic [4:0]  bit_count_reg, bit_count_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] remain_reg, remain_next;
    logic        magic_index_reg, magic_index_next;
    logic        magic_match_reg, magic_match_next;

    // State as seen after an optional restart.
    phase_t      ph;
    logic [7:0]  hc;
    logic [4:0]  bc;
    logic [31:0] acc;
    logic [31:0] rem;
    logic        mi;
    logic        mm;

    phase_t      work_phase;
    logic [31:0] acc_shift;
    logic [31:0] rem_dec;
    logic        byte_done;
    logic        word_done;
    logic        magic_ok;

    assign ph  = restart ? PH_HEADER : phase_reg;
    assign hc  = restart ? 8'd0      : header_count_reg;
    assign bc  = restart ? 5'd0      : bit_count_reg;
    assign acc = restart ? 32'd0     : acc_reg;
    assign rem = restart ? 32'd0     : remain_reg;
    assign mi  = restart ? 1'b0      : magic_index_reg;
    assign mm  = restart ? 1'b1      : magic_match_reg;

    assign acc_shift  = {acc[30:0], carrier_bit};
    assign rem_dec    = rem - 32'd1;
    assign byte_done  = (bc[2:0] == 3'd7);
    assign word_done  = (bc == 5'd31);
    assign work_phase = (ph == PH_HEADER) ? PH_MAGIC : ph;
    assign magic_ok   = mm && (acc_shift[7:0] == cfg.magic_second);

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_count_next    = bit_count_reg;
        acc_next          = acc_reg;
        remain_next       = remain_reg;
        magic_index_next  = magic_index_reg;
        magic_match_next  = magic_match_reg;
        result            = '{valid: 1'b0, kind: K_MAGIC_OK, value: 32'd0, last: 1'b0};

        if (step)
        begin
            phase_next        = ph;
            header_count_next = hc;
            bit_count_next    = bc;
            acc_next          = acc;
            remain_next       = rem;
            magic_index_next  = mi;
            magic_match_next  = mm;

            if (ph == PH_DONE)
            begin
                // frame over: wait for frame_start
            end
            else if ((ph == PH_HEADER) && (hc < cfg.header_bytes))
            begin
                header_count_next = hc + 8'd1;
            end
            else
            begin
                acc_next       = acc_shift;
                bit_count_next = bc + 5'd1;
                phase_next     = work_phase;

                unique case (work_phase)
                    PH_MAGIC:
                    begin
                        if (byte_done)
                        begin
                            bit_count_next = 5'd0;
                            if (!mi)
                            begin
                                magic_match_next = (acc_shift[7:0] == cfg.magic_first);
                                magic_index_next = 1'b1;
                            end
                            else
                            begin
                                magic_match_next = magic_ok;
                                magic_index_next = 1'b0;
                                acc_next         = 32'd0;
                                result.valid     = 1'b1;
                                result.value     = {16'd0, acc_shift[15:0]};
                                if (magic_ok)
                                begin
                                    phase_next  = PH_EXTLEN;
                                    result.kind = K_MAGIC_OK;
                                end
                                else
                                begin
                                    phase_next  = PH_DONE;
                                    result.kind = K_MAGIC_BAD;
                                    result.last = 1'b1;
                                end
                            end
                        end
                    end
                    PH_EXTLEN:
                    begin
                        if (word_done)
                        begin
                            result.valid = 1'b1;
                            result.value = acc_shift;
                            if (!acc_shift[31] && (acc_shift != 32'd0)
                                && (acc_shift <= 32'(MAX_EXT)))
                            begin
                                remain_next = acc_shift;
                                phase_next  = PH_EXT;
                                result.kind = K_EXT_LEN;
                            end
                            else
                            begin
                                phase_next  = PH_DONE;
                                result.kind = K_EXT_BAD;
                                result.last = 1'b1;
                            end
                        end
                    end
                    PH_EXT:
                    begin
                        if (byte_done)
                        begin
                            bit_count_next = 5'd0;
                            remain_next    = rem_dec;
                            if (rem_dec == 32'd0)
                            begin
                                phase_next = PH_DATALEN;
                                acc_next   = {24'd0, acc_shift[7:0]};
                            end
                            result.valid = 1'b1;
                            result.kind  = K_EXT_CHAR;
                            result.value = {24'd0, acc_shift[7:0]};
                        end
                    end
                    PH_DATALEN:
                    begin
                        if (word_done)
                        begin
                            result.valid = 1'b1;
                            result.kind  = K_DATA_LEN;
                            result.value = acc_shift;
                            if (acc_shift[31] || (acc_shift == 32'd0))
                            begin
                                phase_next  = PH_DONE;
                                result.last = 1'b1;
                            end
                            else
                            begin
                                remain_next = acc_shift;
                                phase_next  = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (byte_done)
                        begin
                            bit_count_next = 5'd0;
                            remain_next    = rem_dec;
                            result.valid   = 1'b1;
                            result.kind    = K_DATA_BYTE;
                            result.value   = {24'd0, acc_shift[7:0]};
                            if (rem_dec == 32'd0)
                            begin
                                phase_next  = PH_DONE;
                                result.last = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= 8'd0;
            bit_count_reg    <= 5'd0;
            acc_reg          <= 32'd0;
            remain_reg       <= 32'd0;
            magic_index_reg  <= 1'b0;
            magic_match_reg  <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_count_reg    <= bit_count_next;
            acc_reg          <= acc_next;
            remain_reg       <= remain_next;
            magic_index_reg  <= magic_index_next;
            magic_match_reg  <= magic_match_next;
        end
    end

    // Once done, only a restart leaves the done phase.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !restart && (phase_reg == PH_DONE)) |=> (phase_reg == PH_DONE))
        else $error("lspd_parser: left done phase without frame_start");

    // Extension countdown stays within the accepted range.
    a_ext_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXT) |-> ((remain_reg != 32'd0) && (remain_reg <= 32'(MAX_EXT))))
        else $error("lspd_parser: extension count out of range");

    // Second magic character pending only while reading magic.
    a_magic_index: assert property (@(posedge clk) disable iff (!rst_n)
        magic_index_reg |-> (phase_reg == PH_MAGIC))
        else $error("lspd_parser: magic index set outside magic phase");

endmodule

`default_nettype wire

// ===== sv/lsb_stego_payload_deframer_core.sv =====
// Top level of the LSB stego payload deframer: handshakes, config registers, result register.
//
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+----------------------------------------
// in      | sink      | in_valid / in_ready   | carrier_byte[7:0], frame_start
// out     | source    | out_valid / out_ready | field_kind[2:0], field_value[31:0], frame_last
// cfg     | sink      | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[7:0]
//
// Timing: an item is held in the input register and its result (if any) is registered in
//   the result register when the item advances; sustained rate is one item per cycle while
//   out_ready stays high, set by the state update of the parser.
// Reset: config goes to header 54, magic 35/42; parser starts in header skip.
// Stalls: with out_ready low the result holds and one more item waits in the input
//   register; in_ready then drops. cfg_ready is always high.
`default_nettype none

module lsb_stego_payload_deframer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  carrier_byte,
    input  wire logic        frame_start,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       field_kind,
    output logic signed [31:0] field_value,
    output logic             frame_last,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    import lspd_pkg::*;

    cfg_t    cfg_reg;
    result_t result;

    // input register: only bit 0 of the carrier matters after the header
    logic    s1_valid_reg;
    logic    s1_bit_reg;
    logic    s1_start_reg;

    // result register
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    logic    advance;
    logic    in_accept;

    // The input stage moves on whenever the result register is free or being drained.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes <= HEADER_BYTES_RST;
            cfg_reg.magic_first  <= MAGIC_FIRST_RST;
            cfg_reg.magic_second <= MAGIC_SECOND_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEADER_BYTES: cfg_reg.header_bytes <= cfg_data;
                REG_MAGIC_FIRST:  cfg_reg.magic_first  <= cfg_data;
                REG_MAGIC_SECOND: cfg_reg.magic_second <= cfg_data;
                default:          ;   // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_bit_reg   <= carrier_byte[0];
            s1_start_reg <= frame_start;
        end
    end

    lspd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .carrier_bit (s1_bit_reg),
        .restart     (s1_start_reg),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            out_kind_reg  <= result.kind;
            out_value_reg <= result.value;
            out_last_reg  <= result.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_kind  = out_kind_reg;
    assign field_value = out_value_reg;
    assign frame_last  = out_last_reg;

    // in_ready only drops with an item held in the input register.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg)
        else $error("deframer: in_ready low with empty input stage");

    // frame_last only comes with a kind that can end a frame.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |->
            ((out_kind_reg == K_MAGIC_BAD) || (out_kind_reg == K_EXT_BAD)
             || (out_kind_reg == K_DATA_LEN) || (out_kind_reg == K_DATA_BYTE)))
        else $error("deframer: frame_last on a non-terminal kind");

    // Error kinds always end the frame.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((out_kind_reg == K_MAGIC_BAD) || (out_kind_reg == K_EXT_BAD)))
            |-> frame_last)
        else $error("deframer: error result without frame_last");

endmodule

`default_nettype wire
